// ===== rtl/core/csv_fs_pkg.sv =====
// Shared types, constants and helpers for the CSV field splitter.
package csv_fs_pkg;

    localparam int CHAR_W     = 16;
    localparam int FNUM_W     = 8;
    localparam int MAX_FIELDS = 256;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_DELIMITER_ADDR = 3'd0;

    localparam logic [CHAR_W-1:0] DELIM_RESET = 16'h002C;
    localparam logic [CHAR_W-1:0] CH_QUOTE    = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_TAB      = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_BS       = 16'h0008;
    localparam logic [CHAR_W-1:0] CH_CR       = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_LF       = 16'h000A;

    // parser position within a field
    typedef enum logic [4:0] {
        MODE_SKIP   = 5'b00001,
        MODE_UNQ    = 5'b00010,
        MODE_QUOTED = 5'b00100,
        MODE_QSEEN  = 5'b01000,
        MODE_TAIL   = 5'b10000
    } mode_t;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_CHAR  = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic load_step;
        logic load_blank;
        logic load_hold;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic need_flush;
        logic has_result;
        logic last_blank;
    } status_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_BS) ||
               (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// ===== rtl/core/csv_fs_ctrl.sv =====
// Sequencing controller: accepts items, drives held-blank flushes and result loads.
module csv_fs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  csv_fs_pkg::status_t status,
    output csv_fs_pkg::cmd_t    cmd
);
    import csv_fs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
                if (cmd.accept)
                begin
                    if (status.need_flush)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.load_step = status.has_result;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.load_blank = 1'b1;
                    if (status.last_blank)
                    begin
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_CHAR:
            begin
                if (status.out_free)
                begin
                    cmd.load_hold = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.need_flush) |=> (state_reg == ST_FLUSH))
        else $error("flush not entered after accepted item with held blanks");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> (!cmd.accept && !cmd.load_step))
        else $error("item accepted while flushing");

    a_char_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHAR && status.out_free) |=> (state_reg == ST_RUN))
        else $error("held character not released");

endmodule

// ===== rtl/core/csv_fs_dp.sv =====
// Datapath: field parser, held-blank buffer, field counter and output register.
module csv_fs_dp #(
    parameter int BLANK_DEPTH = 15
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [csv_fs_pkg::CHAR_W-1:0]       delimiter,
    input  logic [csv_fs_pkg::CHAR_W-1:0]       code_unit,
    input  logic                                record_last,
    input  csv_fs_pkg::cmd_t                    cmd,
    output csv_fs_pkg::status_t                 status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [csv_fs_pkg::CHAR_W-1:0]       char_out,
    output logic                                char_valid,
    output logic [csv_fs_pkg::FNUM_W-1:0]       field_number,
    output logic                                field_end,
    output logic                                record_end,
    output logic                                field_overflow,
    output logic                                run_last
);
    import csv_fs_pkg::*;

    localparam int CW = $clog2(BLANK_DEPTH + 1);
    localparam int AW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
    localparam int FW = $clog2(MAX_FIELDS);
    localparam logic [FW-1:0] CNT_MAX = FW'(MAX_FIELDS - 1);
    localparam logic [CW-1:0] PEND_MAX = CW'(BLANK_DEPTH);

    // parser state
    mode_t          mode_reg;
    logic [FW-1:0]  cnt_reg;
    logic           content_reg;
    logic [CW-1:0]  pcount_reg;

    // blank buffer
    logic [CHAR_W-1:0] blank_mem [BLANK_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     flush_cnt_reg;

    // character result held during a flush
    logic [CHAR_W-1:0] hold_char_reg;
    logic              hold_fend_reg;
    logic              hold_rend_reg;
    logic [FNUM_W-1:0] hold_fnum_reg;
    logic              hold_ovf_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_cvalid_reg;
    logic [FNUM_W-1:0] out_fnum_reg;
    logic              out_fend_reg;
    logic              out_rend_reg;
    logic              out_ovf_reg;
    logic              out_rlast_reg;

    mode_t       mode_n;
    logic        do_take;
    logic        close;
    logic        fin;
    logic        blank;
    logic        is_delim;
    logic        is_quote;
    logic        emit_char;
    logic        store;
    logic [FNUM_W-1:0] cur_fnum;
    logic        cur_ovf;

    always_comb
    begin
        is_delim = (code_unit == delimiter);
        is_quote = (code_unit == CH_QUOTE);
        blank    = is_blank(code_unit);
        mode_n   = mode_reg;
        do_take  = 1'b0;
        close    = 1'b0;
        unique case (mode_reg)
            MODE_SKIP:
            begin
                if (code_unit == CH_SPACE || (code_unit == CH_TAB && delimiter != CH_TAB))
                begin
                    mode_n = MODE_SKIP;
                end
                else if (is_quote)
                begin
                    mode_n = MODE_QUOTED;
                end
                else if (is_delim)
                begin
                    close = 1'b1;
                end
                else
                begin
                    mode_n  = MODE_UNQ;
                    do_take = 1'b1;
                end
            end
            MODE_UNQ:
            begin
                close   = is_delim;
                do_take = !is_delim;
            end
            MODE_QUOTED:
            begin
                if (is_quote)
                begin
                    mode_n = MODE_QSEEN;
                end
                else
                begin
                    do_take = 1'b1;
                end
            end
            MODE_QSEEN:
            begin
                // doubled quote yields one quote; anything else ends the quoted part
                if (is_quote)
                begin
                    do_take = 1'b1;
                    mode_n  = MODE_QUOTED;
                end
                else if (is_delim)
                begin
                    close = 1'b1;
                end
                else
                begin
                    mode_n = MODE_TAIL;
                end
            end
            MODE_TAIL:
            begin
                close = is_delim;
            end
            default:
            begin
                mode_n = MODE_TAIL;
                close  = is_delim;
            end
        endcase
        fin       = close || record_last;
        emit_char = do_take && !blank;
        store     = do_take && blank && content_reg && (pcount_reg < PEND_MAX);
        cur_fnum  = FNUM_W'(cnt_reg);
        cur_ovf   = (cnt_reg == CNT_MAX);
    end

    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.need_flush = emit_char && (pcount_reg != '0);
    assign status.has_result = emit_char || fin;
    assign status.last_blank = ((idx_reg + CW'(1)) == flush_cnt_reg);

    // read one ahead so a blank can leave every cycle while the output is free
    assign rd_addr = (cmd.load_blank && !status.last_blank) ?
                     AW'(idx_reg + CW'(1)) : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept && store)
        begin
            blank_mem[pcount_reg[AW-1:0]] <= code_unit;
        end
        rd_data_reg <= blank_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SKIP;
            cnt_reg     <= '0;
            content_reg <= 1'b0;
            pcount_reg  <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (fin)
                begin
                    mode_reg    <= MODE_SKIP;
                    content_reg <= 1'b0;
                    pcount_reg  <= '0;
                    if (record_last)
                    begin
                        cnt_reg <= '0;
                    end
                    else if (cnt_reg != CNT_MAX)
                    begin
                        cnt_reg <= cnt_reg + FW'(1);
                    end
                end
                else
                begin
                    mode_reg <= mode_n;
                    if (emit_char)
                    begin
                        content_reg <= 1'b1;
                        pcount_reg  <= '0;
                    end
                    else if (store)
                    begin
                        pcount_reg <= pcount_reg + CW'(1);
                    end
                end
            end
            if (cmd.load_blank && !status.last_blank)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            else if (cmd.load_hold)
            begin
                idx_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            flush_cnt_reg <= pcount_reg;
            hold_char_reg <= code_unit;
            hold_fend_reg <= fin;
            hold_rend_reg <= fin;
            hold_fnum_reg <= cur_fnum;
            hold_ovf_reg  <= cur_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_step || cmd.load_blank || cmd.load_hold)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            out_char_reg   <= emit_char ? code_unit : '0;
            out_cvalid_reg <= emit_char;
            out_fnum_reg   <= cur_fnum;
            out_fend_reg   <= fin;
            out_rend_reg   <= emit_char ? fin : record_last;
            out_ovf_reg    <= cur_ovf;
            out_rlast_reg  <= 1'b1;
        end
        else if (cmd.load_blank)
        begin
            out_char_reg   <= rd_data_reg;
            out_cvalid_reg <= 1'b1;
            out_fnum_reg   <= hold_fnum_reg;
            out_fend_reg   <= 1'b0;
            out_rend_reg   <= 1'b0;
            out_ovf_reg    <= hold_ovf_reg;
            out_rlast_reg  <= 1'b0;
        end
        else if (cmd.load_hold)
        begin
            out_char_reg   <= hold_char_reg;
            out_cvalid_reg <= 1'b1;
            out_fnum_reg   <= hold_fnum_reg;
            out_fend_reg   <= hold_fend_reg;
            out_rend_reg   <= hold_rend_reg;
            out_ovf_reg    <= hold_ovf_reg;
            out_rlast_reg  <= 1'b1;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign char_out       = out_char_reg;
    assign char_valid     = out_cvalid_reg;
    assign field_number   = out_fnum_reg;
    assign field_end      = out_fend_reg;
    assign record_end     = out_rend_reg;
    assign field_overflow = out_ovf_reg;
    assign run_last       = out_rlast_reg;

endmodule

// ===== rtl/core/csv_field_splitter.sv =====
// Output path: a unit with no held blanks is loaded straight into the output register; a unit
//   that releases held blanks is held while the blanks are loaded, then its own result follows.
// Throughput: one code unit per cycle while the output is free; a unit that releases k held inner
//   blanks (k up to BLANK_DEPTH) blocks input through the flush, one buffer read per emitted blank.
// Input stalls while a result waits and m_tready is low. Reset (rst_n, async, active low):
//   parser, field counter and output valid clear, delimiter to comma; blank buffer kept.
module csv_field_splitter #(
    parameter int BLANK_DEPTH = 15
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [csv_fs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [csv_fs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [csv_fs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,  // [15:0] code_unit
    input  logic                                 s_tlast,  // record_last
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,  // [15:0] char_out, [23:16] field_number
    output logic [3:0]                           m_tuser,  // char_valid, field_end, field_overflow, run_last
    output logic                                 m_tlast   // record_end
);
    import csv_fs_pkg::*;

    logic [CHAR_W-1:0] delimiter_reg;
    logic              cfg_write;
    cmd_t              cmd;
    status_t           status;

    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic [FNUM_W-1:0] field_number;
    logic              field_end;
    logic              record_end;
    logic              field_overflow;
    logic              run_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_DELIMITER_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
        end
        else if (cfg_write)
        begin
            delimiter_reg <= pwdata[CHAR_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_DELIMITER_ADDR: prdata = APB_DATA_W'(delimiter_reg);
            default:            prdata = '0;
        endcase
    end

    csv_fs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csv_fs_dp #(
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .delimiter      (delimiter_reg),
        .code_unit      (s_tdata),
        .record_last    (s_tlast),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .char_out       (char_out),
        .char_valid     (char_valid),
        .field_number   (field_number),
        .field_end      (field_end),
        .record_end     (record_end),
        .field_overflow (field_overflow),
        .run_last       (run_last)
    );

    assign m_tdata = {field_number, char_out};
    assign m_tuser = {run_last, field_overflow, field_end, char_valid};
    assign m_tlast = record_end;

endmodule

// ===== tb/csv_field_splitter_checker.sv =====
// Checker for csv_field_splitter: follows APB writes, predicts each field character, compares results.
`timescale 1ns / 100ps

module csv_field_splitter_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [csv_fs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csv_fs_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [csv_fs_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                  pready,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [15:0]                           s_tdata,   // [15:0] code_unit
    input  logic                                  s_tlast,   // record_last
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [23:0]                           m_tdata,   // [15:0] char_out, [23:16] field_number
    input  logic [3:0]                            m_tuser,   // char_valid, field_end, field_overflow, run_last
    input  logic                                  m_tlast,   // record_end
    output int                                    fail_count,
    output int                                    expected_left
);
    import csv_fs_pkg::*;

    localparam int BLANK_DEPTH = 15;
    localparam logic [FNUM_W-1:0] FIELD_LIMIT = FNUM_W'(MAX_FIELDS - 1);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              cv;
        logic [FNUM_W-1:0] fnum;
        logic              fend;
        logic              rend;
        logic              ovf;
        logic              rlast;
    } field_char_t;

    field_char_t       due_chars[$];
    field_char_t       unit_chars[$];
    logic [CHAR_W-1:0] held_blanks[$];
    mode_t             pmode;
    logic [CHAR_W-1:0] delim;
    logic [FNUM_W-1:0] field_idx;
    logic              value_seen;
    int                n_err = 0;

    function automatic bit trim_char(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_BS || c == CH_CR || c == CH_LF;
    endfunction

    function void emit(input logic [CHAR_W-1:0] c, input logic cv, input logic fe,
                       input logic re);
        unit_chars.push_back('{c, cv, field_idx, fe, re, field_idx >= FIELD_LIMIT, 1'b0});
    endfunction

    // inner blanks wait until a later non-blank value char of the same field
    function void take_char(input logic [CHAR_W-1:0] c);
        if (trim_char(c))
        begin
            if (value_seen && held_blanks.size() < BLANK_DEPTH)
                held_blanks.push_back(c);
        end
        else
        begin
            foreach (held_blanks[i])
                emit(held_blanks[i], 1'b1, 1'b0, 1'b0);
            held_blanks.delete();
            emit(c, 1'b1, 1'b0, 1'b0);
            value_seen = 1'b1;
        end
    endfunction

    function void split_unit(input logic [CHAR_W-1:0] c, input logic lst);
        logic closing;
        int   k;
        closing = 1'b0;
        unit_chars.delete();
        case (pmode)
            MODE_SKIP:
            begin
                if (c == CH_SPACE || (c == CH_TAB && delim != CH_TAB))
                begin
                    // leading blank dropped
                end
                else if (c == CH_QUOTE)
                    pmode = MODE_QUOTED;
                else if (c == delim)
                    closing = 1'b1;
                else
                begin
                    pmode = MODE_UNQ;
                    take_char(c);
                end
            end
            MODE_UNQ:
            begin
                if (c == delim)
                    closing = 1'b1;
                else
                    take_char(c);
            end
            MODE_QUOTED:
            begin
                if (c == CH_QUOTE)
                    pmode = MODE_QSEEN;
                else
                    take_char(c);
            end
            MODE_QSEEN:
            begin
                if (c == CH_QUOTE)
                begin
                    take_char(CH_QUOTE);
                    pmode = MODE_QUOTED;
                end
                else if (c == delim)
                    closing = 1'b1;
                else
                    pmode = MODE_TAIL;
            end
            default:
            begin
                pmode = MODE_TAIL;
                if (c == delim)
                    closing = 1'b1;
            end
        endcase

        if (closing || lst)
        begin
            k = unit_chars.size();
            if (k > 0)
            begin
                unit_chars[k-1].fend = 1'b1;
                unit_chars[k-1].rend = 1'b1;
            end
            else
                emit('0, 1'b0, 1'b1, lst);
            pmode      = MODE_SKIP;
            value_seen = 1'b0;
            held_blanks.delete();
            if (lst)
                field_idx = '0;
            else if (field_idx < FIELD_LIMIT)
                field_idx = field_idx + 1'b1;
        end

        k = unit_chars.size();
        if (k > 0)
            unit_chars[k-1].rlast = 1'b1;
        foreach (unit_chars[i])
            due_chars.push_back(unit_chars[i]);
    endfunction

    function void match_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_err++;
        end
    endfunction

    function void check_char();
        field_char_t want;
        if (due_chars.size() == 0)
        begin
            $error("unexpected transaction: char_out %0h field_number %0d",
                   m_tdata[15:0], m_tdata[23:16]);
            n_err++;
        end
        else
        begin
            want = due_chars.pop_front();
            match_field("char_out", want.ch, m_tdata[15:0]);
            match_field("char_valid", want.cv, m_tuser[0]);
            match_field("field_number", want.fnum, m_tdata[23:16]);
            match_field("field_end", want.fend, m_tuser[1]);
            match_field("record_end", want.rend, m_tlast);
            match_field("field_overflow", want.ovf, m_tuser[2]);
            match_field("run_last", want.rlast, m_tuser[3]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim      = DELIM_RESET;
            pmode      = MODE_SKIP;
            field_idx  = '0;
            value_seen = 1'b0;
            held_blanks.delete();
            due_chars.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite && paddr == REG_DELIMITER_ADDR)
                    delim = pwdata[CHAR_W-1:0];
                else if (!pwrite)
                    match_field("prdata", {16'h0, delim}, prdata);
            end
            // results first: nothing accepted at this edge can show up before the next one
            if (m_tvalid && m_tready)
                check_char();
            if (s_tvalid && s_tready)
                split_unit(s_tdata, s_tlast);
        end
        fail_count    <= n_err;
        expected_left <= due_chars.size();
    end

endmodule

// ===== tb/tb_csv_field_splitter.sv =====
// Top-level testbench for csv_field_splitter: clock, reset, APB setup, record stimulus, verdict.
`timescale 1ns / 100ps

module tb_csv_field_splitter;
    import csv_fs_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [15:0] code_unit
    logic                  s_tlast;   // record_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // [15:0] char_out, [23:16] field_number
    logic [3:0]            m_tuser;   // char_valid, field_end, field_overflow, run_last
    logic                  m_tlast;   // record_end
    int                    fail_count;
    int                    expected_left;

    logic [16:0]           rec_units[$];   // {record_last, code_unit}
    logic [15:0]           delim_set[7];
    bit                    tx_busy = 1'b1;
    bit                    rx_busy = 1'b1;
    int                    rx_count = 0;
    int                    phase_units;

    csv_field_splitter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    csv_field_splitter_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #5 clk = ~clk;

    task send_unit(input logic [15:0] cu, input logic lst);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_busy = !tx_busy;
        gap = tx_busy ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cu;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task send_text(input string s, input logic lst);
        for (int i = 0; i < s.len(); i++)
            send_unit(16'(s[i]), lst && i == s.len() - 1);
    endtask

    task wait_drained();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0 && n < 50000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
    endtask

    task apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task set_delimiter(input logic [15:0] d);
        wait_drained();
        apb_xfer(1'b1, REG_DELIMITER_ADDR, {16'h0, d});
        apb_xfer(1'b0, REG_DELIMITER_ADDR, '0);
    endtask

    function logic [15:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_BS;
            3:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function logic [15:0] pick_char();
        case ($urandom_range(0, 7))
            5:       return 16'h0030 + 16'($urandom_range(0, 9));
            6, 7:    return 16'($urandom_range(0, 65535));
            default: return 16'h0061 + 16'($urandom_range(0, 25));
        endcase
    endfunction

    function void add_unit(input logic [15:0] cu);
        rec_units.push_back({1'b0, cu});
    endfunction

    // mostly well-formed fields with random content, plus raw noise fields
    function void build_record(input logic [15:0] d);
        int nf;
        int n;
        rec_units.delete();
        nf = $urandom_range(1, 6);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                add_unit(d);
            case ($urandom_range(0, 9))
                0:
                begin
                    // empty field
                end
                1, 2, 3, 4:
                begin
                    repeat ($urandom_range(0, 2))
                        add_unit($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++)
                    begin
                        if (i > 0 && $urandom_range(0, 3) == 0)
                            repeat ($urandom_range(1, 3))
                                add_unit(pick_blank());
                        add_unit(pick_char());
                    end
                    repeat ($urandom_range(0, 2))
                        add_unit(pick_blank());
                end
                5, 6:
                begin
                    if ($urandom_range(0, 1))
                        add_unit(CH_SPACE);
                    add_unit(CH_QUOTE);
                    n = $urandom_range(0, 5);
                    for (int i = 0; i < n; i++)
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                add_unit(CH_QUOTE);
                                add_unit(CH_QUOTE);
                            end
                            1:       add_unit(d);
                            2:       add_unit(pick_blank());
                            default: add_unit(pick_char());
                        endcase
                    end
                    // now and then left open so the value runs on
                    if ($urandom_range(0, 9) != 0)
                        add_unit(CH_QUOTE);
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2))
                            add_unit(pick_char());
                end
                7:
                begin
                    // inner blank run of 14 to 18 units, around the hold buffer depth and often longer
                    add_unit(16'h0078);
                    repeat ($urandom_range(14, 18))
                        add_unit(pick_blank());
                    add_unit(16'h0079);
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                        add_unit(16'($urandom_range(0, 65535)));
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0 || rec_units.size() == 0)
            add_unit(d);
        rec_units[rec_units.size() - 1][16] = 1'b1;
    endfunction

    task send_record();
        foreach (rec_units[i])
            send_unit(rec_units[i][15:0], rec_units[i][16]);
    endtask

    // receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        int  gap;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                rx_busy = !rx_busy;
            if (!held && rx_count >= 120)
            begin
                held = 1'b1;
                gap  = 300;
            end
            else
                gap = rx_busy ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            rx_count++;
        end
    end

    initial
    begin
        #10_000_000;
        $display("[csv_field_splitter] ERROR");
        $finish;
    end

    initial
    begin
        delim_set = '{16'h002C, CH_TAB, CH_SPACE, CH_QUOTE, 16'h0000, 16'hFFFF, 16'h0000};
        delim_set[6] = 16'($urandom_range(0, 65535));
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset delimiter: leading blanks, extreme units, inner and trailing blanks,
        // doubled quote, text after closing quote, record ending on a delimiter
        send_unit(CH_SPACE, 1'b0);
        send_unit(CH_TAB, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(CH_SPACE, 1'b0);
        send_text("a", 1'b0);
        send_unit(CH_TAB, 1'b0);
        send_unit(CH_BS, 1'b0);
        send_unit(CH_LF, 1'b0);
        send_text("b", 1'b0);
        send_unit(CH_SPACE, 1'b0);
        send_unit(CH_CR, 1'b0);
        send_text(",\"q\"\"z\" t,", 1'b1);
        // plain quote inside a value, then a quote never closed
        send_unit(16'h0000, 1'b0);
        send_text("\",\"u", 1'b1);

        foreach (delim_set[d])
        begin
            set_delimiter(delim_set[d]);
            if (d == 0)
            begin
                // run the field number into saturation
                repeat (258)
                    send_unit(16'h002C, 1'b0);
                send_text("z", 1'b1);
            end
            phase_units = 0;
            while (phase_units < 12)
            begin
                build_record(delim_set[d]);
                send_record();
                phase_units += rec_units.size();
            end
        end

        wait_drained();
        if (expected_left != 0)
            $error("%0d expected transactions never arrived", expected_left);
        if (fail_count == 0 && expected_left == 0)
            $display("[csv_field_splitter] OK");
        else
            $display("[csv_field_splitter] ERROR");
        $finish;
    end

endmodule
